// File: src/hsi_pkg.sv
package hsi_pkg;

  // patch geometry and number formats
  localparam int QUADS_PER_SIDE = 32;
  localparam int QUAD_SIZE_LOG2 = 1;
  localparam int HEIGHT_BITS    = 24;
  localparam int FRACTION_BITS  = 8;

  localparam int VERTS_PER_SIDE = QUADS_PER_SIDE + 1;
  localparam int STORE_DEPTH    = VERTS_PER_SIDE * VERTS_PER_SIDE;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int COORD_W        = 6;
  localparam int OFF_W          = 14;
  localparam int CMD_W          = 3;
  localparam int FRAC_ONE       = 1 << FRACTION_BITS;
  localparam int WGT_W          = FRACTION_BITS + 1;
  localparam int PROD_W         = HEIGHT_BITS + WGT_W + 1;
  localparam int ACC_W          = PROD_W + 1;
  localparam int STEP_W         = 3;
  localparam int NUM_CORNERS    = 3;

  localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 3'd0,
    CMD_RAISE  = 3'd1,
    CMD_LOWER  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_INTERP = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_ITP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]                cmd;
    logic [COORD_W-1:0]              vertex_x;
    logic [COORD_W-1:0]              vertex_y;
    logic signed [HEIGHT_BITS-1:0]   height_in;
    logic [OFF_W-1:0]                offset_x;
    logic [OFF_W-1:0]                offset_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0]   height_out;
    logic signed [HEIGHT_BITS-1:0]   bound_low;
    logic signed [HEIGHT_BITS-1:0]   bound_high;
    logic                            bounds_widened;
  } out_beat_t;

  // address decode and triangle setup for one beat
  typedef struct packed {
    logic                                     in_range;
    logic [ADDR_W-1:0]                        addr;
    logic [NUM_CORNERS-1:0][ADDR_W-1:0]       corner_addr;
    logic [NUM_CORNERS-1:0][WGT_W-1:0]        weight;
  } geom_t;

  // multiply-accumulate step control
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_load;
  } mac_ctrl_t;

  // row-major vertex address
  function automatic logic [ADDR_W-1:0] vert_addr(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'(y) * ADDR_W'(VERTS_PER_SIDE);
    return row + ADDR_W'(x);
  endfunction

endpackage

// File: src/heightmap_store_interpolate.sv
// reads and vertex writes pass S_READ, S_UPDATE and S_DONE from accept to result valid,
//   interpolation S_ITP and S_DONE, out-of-range vertex and unused commands S_DONE only
// one item at a time, accepted only in S_IDLE after the last result is registered;
//   interpolation reads corners via the single store read port, one corner per cycle
// reset: bounds go to most positive (low) and most negative (high); store contents
//   stay undefined until written, no clearing pass
module heightmap_store_interpolate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsi_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsi_pkg::out_beat_t out_beat_o
);

  hsi_pkg::state_e state_q, state_d;
  hsi_pkg::geom_t  geom;
  hsi_pkg::mac_ctrl_t mac_ctrl;

  logic [hsi_pkg::CMD_W-1:0]        cmd_q;
  logic signed [hsi_pkg::HEIGHT_BITS-1:0] h_q, res_q, res_d, low_q, low_d, high_q, high_d;
  logic signed [hsi_pkg::HEIGHT_BITS-1:0] old_h, mac_res;
  logic [hsi_pkg::ADDR_W-1:0]       addr_q, raddr;
  logic [hsi_pkg::NUM_CORNERS-1:0][hsi_pkg::ADDR_W-1:0] corner_q;
  logic [hsi_pkg::NUM_CORNERS-1:0][hsi_pkg::WGT_W-1:0]  weight_q;
  logic [hsi_pkg::WGT_W-1:0]        weight_sel;
  logic [hsi_pkg::STEP_W-1:0]       step_q;
  logic                             wid_q, wid_d, do_wr;
  logic                             accept, slot_free, mem_re, mem_we, done_fire;
  logic                             out_valid_q;
  hsi_pkg::out_beat_t               out_beat_q;
  logic [hsi_pkg::HEIGHT_BITS-1:0]  rdata;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign old_h     = $signed(rdata);

  hsi_geom u_geom (
    .beat_i (in_beat_i),
    .geom_o (geom)
  );

  hsi_ram #(
    .DEPTH (hsi_pkg::STORE_DEPTH),
    .WIDTH (hsi_pkg::HEIGHT_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (h_q),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hsi_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .height_i (old_h),
    .weight_i (weight_sel),
    .result_o (mac_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hsi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_beat_i.cmd) inside
            hsi_pkg::CMD_SET, hsi_pkg::CMD_RAISE, hsi_pkg::CMD_LOWER, hsi_pkg::CMD_READ: begin
              state_d = geom.in_range ? hsi_pkg::S_READ : hsi_pkg::S_DONE;
            end
            hsi_pkg::CMD_INTERP: state_d = hsi_pkg::S_ITP;
            default:             state_d = hsi_pkg::S_DONE;
          endcase
        end
      end
      hsi_pkg::S_READ:   state_d = hsi_pkg::S_UPDATE;
      hsi_pkg::S_UPDATE: state_d = hsi_pkg::S_DONE;
      hsi_pkg::S_ITP: begin
        if (step_q == hsi_pkg::STEP_W'(hsi_pkg::NUM_CORNERS + 1)) begin
          state_d = hsi_pkg::S_DONE;
        end
      end
      hsi_pkg::S_DONE: begin
        if (slot_free) begin
          state_d = hsi_pkg::S_IDLE;
        end
      end
      default: state_d = hsi_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake, memory port, mac schedule
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    raddr      = addr_q;
    weight_sel = weight_q[0];
    mac_ctrl   = '0;
    done_fire  = 1'b0;
    unique case (state_q)
      hsi_pkg::S_IDLE: in_ready_o = 1'b1;
      hsi_pkg::S_READ: mem_re = 1'b1;
      hsi_pkg::S_ITP: begin
        // step k reads corner k, weighs corner k-1, sums corner k-2
        case (step_q)
          3'd0: begin
            mem_re = 1'b1;
            raddr  = corner_q[0];
          end
          3'd1: begin
            mem_re          = 1'b1;
            raddr           = corner_q[1];
            mac_ctrl.mul_en = 1'b1;
            weight_sel      = weight_q[0];
          end
          3'd2: begin
            mem_re            = 1'b1;
            raddr             = corner_q[2];
            mac_ctrl.mul_en   = 1'b1;
            weight_sel        = weight_q[1];
            mac_ctrl.acc_en   = 1'b1;
            mac_ctrl.acc_load = 1'b1;
          end
          3'd3: begin
            mac_ctrl.mul_en = 1'b1;
            weight_sel      = weight_q[2];
            mac_ctrl.acc_en = 1'b1;
          end
          3'd4: mac_ctrl.acc_en = 1'b1;
          default: ;
        endcase
      end
      hsi_pkg::S_DONE: done_fire = slot_free;
      default: ;
    endcase
  end

  // read-modify-write decision and bound update
  always_comb begin
    case (cmd_q)
      hsi_pkg::CMD_SET:   do_wr = 1'b1;
      hsi_pkg::CMD_RAISE: do_wr = h_q > old_h;
      hsi_pkg::CMD_LOWER: do_wr = h_q < old_h;
      default:            do_wr = 1'b0;
    endcase
    mem_we = (state_q == hsi_pkg::S_UPDATE) && do_wr;
    res_d  = do_wr ? h_q : old_h;
    low_d  = low_q;
    high_d = high_q;
    wid_d  = 1'b0;
    if (cmd_q != hsi_pkg::CMD_READ) begin
      if (h_q > high_q) begin
        high_d = h_q;
        wid_d  = 1'b1;
      end
      if (h_q < low_q) begin
        low_d = h_q;
        wid_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsi_pkg::S_IDLE;
      step_q      <= '0;
      low_q       <= hsi_pkg::HEIGHT_MAX;
      high_q      <= hsi_pkg::HEIGHT_MIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == hsi_pkg::S_ITP) begin
        step_q <= step_q + hsi_pkg::STEP_W'(1);
      end
      if (state_q == hsi_pkg::S_UPDATE) begin
        low_q  <= low_d;
        high_q <= high_d;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_beat_i.cmd;
      h_q      <= in_beat_i.height_in;
      addr_q   <= geom.addr;
      corner_q <= geom.corner_addr;
      weight_q <= geom.weight;
      res_q    <= '0;
      wid_q    <= 1'b0;
    end else if (state_q == hsi_pkg::S_UPDATE) begin
      res_q <= res_d;
      wid_q <= wid_d;
    end
    if (done_fire) begin
      out_beat_q.height_out     <= (cmd_q == hsi_pkg::CMD_INTERP) ? mac_res : res_q;
      out_beat_q.bound_low      <= low_q;
      out_beat_q.bound_high     <= high_q;
      out_beat_q.bounds_widened <= wid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // a widening write leaves the bounds ordered
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.bounds_widened |->
      out_beat_o.bound_low <= out_beat_o.bound_high)
    else $error("bounds out of order after widening write");

  // a new result only comes out of the done state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == hsi_pkg::S_DONE)
    else $error("result raised outside done state");

  // bounds move only in the update step
  a_bounds_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(low_q) || !$stable(high_q) |-> $past(state_q) == hsi_pkg::S_UPDATE)
    else $error("bounds changed outside update step");

  // the store is never written during interpolation
  a_no_write_in_itp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hsi_pkg::S_ITP |-> !mem_we)
    else $error("store written during interpolation");

endmodule

// File: src/hsi_ram.sv
module hsi_ram #(
  parameter int DEPTH = 1089,
  parameter int WIDTH = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/hsi_geom.sv
module hsi_geom (
  input  hsi_pkg::in_beat_t beat_i,
  output hsi_pkg::geom_t    geom_o
);

  localparam int SUM_W = hsi_pkg::WGT_W + 1;

  logic [hsi_pkg::COORD_W-1:0] cx, cy, cx1, cy1;
  logic [hsi_pkg::WGT_W-1:0]   fx, fy;
  logic [SUM_W-1:0]            ex, ey, one, fsum;
  logic [hsi_pkg::ADDR_W-1:0]  a_bl, a_br, a_tl, a_tr;

  // cell and fraction of one axis, saturated at the far edge
  function automatic logic [hsi_pkg::COORD_W+hsi_pkg::WGT_W-1:0] split_axis(
      logic [hsi_pkg::OFF_W-1:0] off);
    logic [hsi_pkg::OFF_W-1:0]   raw;
    logic [hsi_pkg::COORD_W-1:0] cell_idx;
    logic [hsi_pkg::WGT_W-1:0]   frac;
    raw = off >> (hsi_pkg::FRACTION_BITS + hsi_pkg::QUAD_SIZE_LOG2);
    if (raw >= hsi_pkg::OFF_W'(hsi_pkg::QUADS_PER_SIDE)) begin
      cell_idx = hsi_pkg::COORD_W'(hsi_pkg::QUADS_PER_SIDE - 1);
      frac     = hsi_pkg::WGT_W'(hsi_pkg::FRAC_ONE);
    end else begin
      cell_idx = hsi_pkg::COORD_W'(raw);
      frac     = hsi_pkg::WGT_W'(off[hsi_pkg::QUAD_SIZE_LOG2 +: hsi_pkg::FRACTION_BITS]);
    end
    return {cell_idx, frac};
  endfunction

  // query split and corner addresses
  always_comb begin
    {cx, fx} = split_axis(beat_i.offset_x);
    {cy, fy} = split_axis(beat_i.offset_y);
    cx1  = cx + hsi_pkg::COORD_W'(1);
    cy1  = cy + hsi_pkg::COORD_W'(1);
    ex   = SUM_W'(fx);
    ey   = SUM_W'(fy);
    one  = SUM_W'(hsi_pkg::FRAC_ONE);
    fsum = ex + ey;
    a_bl = hsi_pkg::vert_addr(cx, cy);
    a_br = hsi_pkg::vert_addr(cx1, cy);
    a_tl = hsi_pkg::vert_addr(cx, cy1);
    a_tr = hsi_pkg::vert_addr(cx1, cy1);
  end

  // triangle choice by cell parity and barycentric weights
  always_comb begin
    geom_o.in_range = (beat_i.vertex_x <= hsi_pkg::COORD_W'(hsi_pkg::QUADS_PER_SIDE)) &&
                      (beat_i.vertex_y <= hsi_pkg::COORD_W'(hsi_pkg::QUADS_PER_SIDE));
    geom_o.addr     = hsi_pkg::vert_addr(beat_i.vertex_x, beat_i.vertex_y);
    if (cx[0] ^ cy[0]) begin
      if (fx > fy) begin
        geom_o.corner_addr = {a_tr, a_br, a_bl};
        geom_o.weight      = {hsi_pkg::WGT_W'(ey), hsi_pkg::WGT_W'(ex - ey),
                              hsi_pkg::WGT_W'(one - ex)};
      end else begin
        geom_o.corner_addr = {a_tr, a_tl, a_bl};
        geom_o.weight      = {hsi_pkg::WGT_W'(ex), hsi_pkg::WGT_W'(ey - ex),
                              hsi_pkg::WGT_W'(one - ey)};
      end
    end else begin
      if (fsum > one) begin
        geom_o.corner_addr = {a_tr, a_tl, a_br};
        geom_o.weight      = {hsi_pkg::WGT_W'(fsum - one), hsi_pkg::WGT_W'(one - ex),
                              hsi_pkg::WGT_W'(one - ey)};
      end else begin
        geom_o.corner_addr = {a_tl, a_br, a_bl};
        geom_o.weight      = {hsi_pkg::WGT_W'(ey), hsi_pkg::WGT_W'(ex),
                              hsi_pkg::WGT_W'(one - fsum)};
      end
    end
  end

endmodule

// File: src/hsi_mac.sv
module hsi_mac (
  input  logic                                clk_i,
  input  hsi_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [hsi_pkg::HEIGHT_BITS-1:0] height_i,
  input  logic [hsi_pkg::WGT_W-1:0]           weight_i,
  output logic signed [hsi_pkg::HEIGHT_BITS-1:0] result_o
);

  logic signed [hsi_pkg::PROD_W-1:0] prod_q;
  logic signed [hsi_pkg::ACC_W-1:0]  acc_q;
  logic signed [hsi_pkg::ACC_W-1:0]  prod_ext, rounded;

  assign prod_ext = hsi_pkg::ACC_W'(prod_q);

  // registered product, then accumulate
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= hsi_pkg::PROD_W'(height_i * $signed({1'b0, weight_i}));
    end
    if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.acc_load ? prod_ext : acc_q + prod_ext;
    end
  end

  // round to nearest, ties upward
  always_comb begin
    rounded  = (acc_q + hsi_pkg::ACC_W'(hsi_pkg::FRAC_ONE / 2)) >>> hsi_pkg::FRACTION_BITS;
    result_o = rounded[hsi_pkg::HEIGHT_BITS-1:0];
  end

endmodule

// File: dv/tb_heightmap_store_interpolate.sv
`timescale 1ns / 1ps

module tb_heightmap_store_interpolate;
  import hsi_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 3;
  localparam int RANDOM_ITEMS  = 740;
  localparam int PHASE_ITEMS   = 150;
  localparam int DRAIN_EVERY   = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int CELL_SHIFT    = FRACTION_BITS + QUAD_SIZE_LOG2;

  // command codes with no operation behind them
  localparam logic [CMD_W-1:0] CMD_NOP_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NOP_LAST  = 3'd7;

  typedef struct {
    in_beat_t beat;
    bit       wait_drain;
  } stim_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  heightmap_store_interpolate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // predicted patch contents and bounds
  logic signed [HEIGHT_BITS-1:0] patch_vert [STORE_DEPTH];
  logic signed [HEIGHT_BITS-1:0] patch_low  = HEIGHT_MAX;
  logic signed [HEIGHT_BITS-1:0] patch_high = HEIGHT_MIN;

  stim_t     pending_q[$];
  out_beat_t height_results_q[$];
  out_beat_t oldest_result;
  bit        written_map [STORE_DEPTH];
  int        accepted_cnt = 0;
  int        err_cnt      = 0;
  int        cycle_cnt    = 0;

  function automatic int vidx(int x, int y);
    return y * VERTS_PER_SIDE + x;
  endfunction

  // one query axis to cell and fraction, saturating at the far edge
  function automatic void locate_axis(input int off, output int cell_idx, output int frac);
    int c;
    c = off >> CELL_SHIFT;
    if (c >= QUADS_PER_SIDE) begin
      cell_idx = QUADS_PER_SIDE - 1;
      frac     = FRAC_ONE;
    end else begin
      cell_idx = c;
      frac     = (off >> QUAD_SIZE_LOG2) & (FRAC_ONE - 1);
    end
  endfunction

  // barycentric height over the triangle that holds the point
  function automatic logic signed [HEIGHT_BITS-1:0] surface_height(int ox, int oy);
    int     cx, cy, fx, fy;
    longint bl, br, tl, tr, sum;
    locate_axis(ox, cx, fx);
    locate_axis(oy, cy, fy);
    bl = patch_vert[vidx(cx, cy)];
    br = patch_vert[vidx(cx + 1, cy)];
    tl = patch_vert[vidx(cx, cy + 1)];
    tr = patch_vert[vidx(cx + 1, cy + 1)];
    if (((cx + cy) & 1) != 0) begin
      if (fx > fy)
        sum = bl * (FRAC_ONE - fx) + br * (fx - fy) + tr * fy;
      else
        sum = bl * (FRAC_ONE - fy) + tl * (fy - fx) + tr * fx;
    end else begin
      if (fx + fy > FRAC_ONE)
        sum = br * (FRAC_ONE - fy) + tl * (FRAC_ONE - fx) + tr * (fx + fy - FRAC_ONE);
      else
        sum = bl * (FRAC_ONE - fx - fy) + br * fx + tl * fy;
    end
    // round to nearest, ties up
    return HEIGHT_BITS'((sum + FRAC_ONE / 2) >>> FRACTION_BITS);
  endfunction

  // apply one command to the predicted patch and return its result beat
  function automatic out_beat_t apply_patch_cmd(in_beat_t b);
    out_beat_t                     r;
    logic signed [HEIGHT_BITS-1:0] h;
    bit                            in_range;
    int                            idx;
    r        = '0;
    h        = b.height_in;
    in_range = (b.vertex_x <= QUADS_PER_SIDE) && (b.vertex_y <= QUADS_PER_SIDE);
    idx      = vidx(b.vertex_x, b.vertex_y);
    case (b.cmd)
      CMD_SET, CMD_RAISE, CMD_LOWER: begin
        if (in_range) begin
          if (b.cmd == CMD_SET || (b.cmd == CMD_RAISE && h > patch_vert[idx]) ||
              (b.cmd == CMD_LOWER && h < patch_vert[idx]))
            patch_vert[idx] = h;
          r.height_out = patch_vert[idx];
          // bounds follow the requested height, stored or not
          if (h > patch_high) begin
            patch_high       = h;
            r.bounds_widened = 1'b1;
          end
          if (h < patch_low) begin
            patch_low        = h;
            r.bounds_widened = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (in_range) r.height_out = patch_vert[idx];
      end
      CMD_INTERP: begin
        r.height_out = surface_height(b.offset_x, b.offset_y);
      end
      default: ;
    endcase
    r.bound_low  = patch_low;
    r.bound_high = patch_high;
    return r;
  endfunction

  function automatic in_beat_t make_beat(logic [CMD_W-1:0] cmd, int x, int y, int h,
                                         int ox, int oy);
    in_beat_t b;
    b.cmd       = cmd;
    b.vertex_x  = COORD_W'(x);
    b.vertex_y  = COORD_W'(y);
    b.height_in = HEIGHT_BITS'(h);
    b.offset_x  = OFF_W'(ox);
    b.offset_y  = OFF_W'(oy);
    return b;
  endfunction

  // query offset for a cell and fraction, the sub-fraction bit random
  function automatic int query_off(int cell_idx, int frac);
    return (cell_idx << CELL_SHIFT) | (frac << QUAD_SIZE_LOG2) | $urandom_range(0, 1);
  endfunction

  function automatic int rand_height();
    if ($urandom_range(0, 9) < 7) return $urandom;
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  // often a small corner of the patch so queries find written cells early
  function automatic int rand_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom_range(0, 5);
    if (roll < 92) return $urandom_range(0, QUADS_PER_SIDE);
    return $urandom_range(QUADS_PER_SIDE + 1, (1 << COORD_W) - 1);
  endfunction

  function automatic int idle_pct(bit sender);
    case ((accepted_cnt / PHASE_ITEMS) % 4)
      0: return 0;
      1: return sender ? 48 : 0;
      2: return sender ? 0 : 48;
      default: return 10;
    endcase
  endfunction

  task automatic push_beat(in_beat_t b, bit drain);
    stim_t s;
    s.beat       = b;
    s.wait_drain = drain;
    pending_q.insert(pending_q.size(), s);
    if (b.cmd == CMD_SET && b.vertex_x <= QUADS_PER_SIDE && b.vertex_y <= QUADS_PER_SIDE)
      written_map[vidx(b.vertex_x, b.vertex_y)] = 1'b1;
  endtask

  task automatic report_mismatch(string what);
    err_cnt++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // directed corner cases
  task automatic add_directed();
    push_beat(make_beat(CMD_SET, 0, 0, 1000, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 1, 0, -700, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 0, 1, 256, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 1, 1, 384, 0, 0), 1'b0);
    push_beat(make_beat(CMD_RAISE, 1, 1, 512, 0, 0), 1'b0);
    push_beat(make_beat(CMD_RAISE, 1, 1, 100, 0, 0), 1'b0);
    push_beat(make_beat(CMD_LOWER, 0, 1, -512, 0, 0), 1'b0);
    push_beat(make_beat(CMD_LOWER, 0, 1, 0, 0, 0), 1'b0);
    push_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0), 1'b0);
    push_beat(make_beat(CMD_READ, QUADS_PER_SIDE + 1, 0, 0, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 63, 63, HEIGHT_MAX, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, QUADS_PER_SIDE, QUADS_PER_SIDE + 1, HEIGHT_MIN, 0, 0), 1'b0);
    push_beat(make_beat(CMD_NOP_FIRST, 0, 0, 0, 0, 0), 1'b0);
    push_beat(make_beat(CMD_NOP_LAST, 63, 63, -1, 16383, 16383), 1'b0);
    // triangles of an even cell, including the diagonal itself
    push_beat(make_beat(CMD_INTERP, 0, 0, 0, 0, 0), 1'b0);
    push_beat(make_beat(CMD_INTERP, 0, 0, 0, 511, 511), 1'b0);
    push_beat(make_beat(CMD_INTERP, 0, 0, 0, query_off(0, 128), query_off(0, 128)), 1'b0);
    // odd cell with extreme heights on its right edge
    push_beat(make_beat(CMD_SET, 2, 0, HEIGHT_MAX, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 2, 1, HEIGHT_MIN, 0, 0), 1'b0);
    push_beat(make_beat(CMD_INTERP, 0, 0, 0, query_off(1, 200), query_off(0, 50)), 1'b0);
    push_beat(make_beat(CMD_INTERP, 0, 0, 0, query_off(1, 60), query_off(0, 60)), 1'b0);
    // far corner of the patch at the largest offsets
    push_beat(make_beat(CMD_SET, 31, 31, HEIGHT_MIN, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 32, 31, -1, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 31, 32, HEIGHT_MAX, 0, 0), 1'b0);
    push_beat(make_beat(CMD_SET, 32, 32, HEIGHT_MAX, 0, 0), 1'b0);
    push_beat(make_beat(CMD_INTERP, 0, 0, 0, 16383, 16383), 1'b0);
  endtask

  // random commands; reads and queries only touch written vertices
  task automatic add_random();
    in_beat_t b;
    int       useful, n, roll, cx, cy, idx;
    bit       found;
    useful = 0;
    n      = 0;
    while (useful < RANDOM_ITEMS) begin
      b.height_in = HEIGHT_BITS'(rand_height());
      b.offset_x  = OFF_W'($urandom);
      b.offset_y  = OFF_W'($urandom);
      b.vertex_x  = COORD_W'(rand_coord());
      b.vertex_y  = COORD_W'(rand_coord());
      roll        = $urandom_range(0, 99);
      if (roll < 8)       b.cmd = CMD_W'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
      else if (roll < 30) b.cmd = CMD_SET;
      else if (roll < 40) b.cmd = CMD_RAISE;
      else if (roll < 50) b.cmd = CMD_LOWER;
      else if (roll < 60) b.cmd = CMD_READ;
      else                b.cmd = CMD_INTERP;

      if (b.cmd == CMD_INTERP) begin
        cx = ($urandom_range(0, 99) < 45) ? $urandom_range(0, 4) : $urandom_range(0, 31);
        cy = ($urandom_range(0, 99) < 45) ? $urandom_range(0, 4) : $urandom_range(0, 31);
        b.offset_x = OFF_W'(query_off(cx, $urandom_range(0, FRAC_ONE - 1)));
        b.offset_y = OFF_W'(query_off(cy, $urandom_range(0, FRAC_ONE - 1)));
        // fill the cell first where a corner is still missing
        found = 1'b0;
        for (int dy = 0; dy < 2; dy++) begin
          for (int dx = 0; dx < 2; dx++) begin
            if (!found && !written_map[vidx(cx + dx, cy + dy)]) begin
              found      = 1'b1;
              b.cmd      = CMD_SET;
              b.vertex_x = COORD_W'(cx + dx);
              b.vertex_y = COORD_W'(cy + dy);
            end
          end
        end
      end else if (b.cmd inside {CMD_RAISE, CMD_LOWER, CMD_READ} &&
                   b.vertex_x <= QUADS_PER_SIDE && b.vertex_y <= QUADS_PER_SIDE) begin
        idx = vidx(b.vertex_x, b.vertex_y);
        if (!written_map[idx]) b.cmd = CMD_SET;
      end

      if (b.cmd == CMD_INTERP ||
          (b.cmd < CMD_NOP_FIRST && b.vertex_x <= QUADS_PER_SIDE &&
           b.vertex_y <= QUADS_PER_SIDE))
        useful++;
      push_beat(b, (n % DRAIN_EVERY) == 0);
      n++;
    end
  endtask

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        height_results_q.insert(height_results_q.size(), apply_patch_cmd(in_beat));
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 &&
            !(pending_q[0].wait_drain && height_results_q.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_beat  <= pending_q[0].beat;
          in_valid <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (height_results_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          oldest_result = height_results_q.pop_front();
          if (out_beat.height_out !== oldest_result.height_out)
            report_mismatch($sformatf("height_out %0d, predicted %0d",
                                      out_beat.height_out, oldest_result.height_out));
          if (out_beat.bound_low !== oldest_result.bound_low)
            report_mismatch($sformatf("bound_low %0d, predicted %0d",
                                      out_beat.bound_low, oldest_result.bound_low));
          if (out_beat.bound_high !== oldest_result.bound_high)
            report_mismatch($sformatf("bound_high %0d, predicted %0d",
                                      out_beat.bound_high, oldest_result.bound_high));
          if (out_beat.bounds_widened !== oldest_result.bounds_widened)
            report_mismatch($sformatf("bounds_widened %0b, predicted %0b",
                                      out_beat.bounds_widened,
                                      oldest_result.bounds_widened));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    add_directed();
    add_random();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_valid || height_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
